// File: hw/rtl/rrmpq_pkg.sv
package rrmpq_pkg;
	localparam int NUM_PIPES = 8;
	localparam int PIPE_DEPTH = 16;
	localparam int BATCH_MAX = 16;
	localparam int MODE_W = 3;
	localparam int SEL_W = 3;
	localparam int DATA_W = 32;
	localparam int LIM_W = 5;

	localparam logic [MODE_W-1:0] MODE_SUB = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ENQ = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DEQ = 3'd2;
	localparam logic [MODE_W-1:0] MODE_BATCH = 3'd3;
	localparam logic [MODE_W-1:0] MODE_UNSUB = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SEL_W-1:0] pipe_sel;
		logic signed [DATA_W-1:0] data_in;
		logic [LIM_W-1:0] batch_limit;
	} req_t;

	typedef struct packed {
		logic ok;
		logic signed [DATA_W-1:0] data_out;
		logic [SEL_W-1:0] pipe_out;
		logic [LIM_W-1:0] batch_total;
		logic last;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic pick;
		logic pop;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_pop;
		logic more;
	} sts_t;
endpackage

// File: hw/rtl/rrmpq_if.sv
interface rrmpq_req_if;
	logic valid;
	logic ready;
	rrmpq_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rrmpq_rsp_if;
	logic valid;
	logic ready;
	rrmpq_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/rrmpq_ctrl.sv
module rrmpq_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input rrmpq_pkg::sts_t sts,
	output rrmpq_pkg::cmd_t cmd
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_POP = 2'd2;

	logic [1:0] state_q;
	logic out_free;

	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		case (state_q)
			ST_EXEC: begin
				cmd.exec = !sts.is_pop && out_free;
				cmd.pick = sts.is_pop;
			end
			ST_POP: cmd.pop = out_free;
			default: ;
		endcase
		cmd.emit = cmd.exec || cmd.pop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (cmd.emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (cmd.load) state_q <= ST_EXEC;
				ST_EXEC: begin
					if (sts.is_pop) state_q <= ST_POP;
					else if (out_free) state_q <= ST_IDLE;
				end
				ST_POP: if (out_free && !sts.more) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !cmd.emit) else $error("emit in idle");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("word dropped");
	a_one_src: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.exec && cmd.pop)) else $error("exec and pop together");
`endif
endmodule

// File: hw/rtl/rrmpq_dp.sv
module rrmpq_dp #(
	parameter int NUM_PIPES = rrmpq_pkg::NUM_PIPES,
	parameter int PIPE_DEPTH = rrmpq_pkg::PIPE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input rrmpq_pkg::req_t req,
	input rrmpq_pkg::cmd_t cmd,
	output rrmpq_pkg::sts_t sts,
	output rrmpq_pkg::rsp_t rsp_q
);
	localparam int PW = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
	localparam int DW = $clog2(PIPE_DEPTH);
	localparam int CW = $clog2(PIPE_DEPTH + 1);
	localparam int TW = $clog2(NUM_PIPES * PIPE_DEPTH + 1);
	localparam int SW = rrmpq_pkg::SEL_W;
	localparam int LW = rrmpq_pkg::LIM_W;

	logic [rrmpq_pkg::DATA_W-1:0] mem [NUM_PIPES][PIPE_DEPTH];
	logic [DW-1:0] head_q [NUM_PIPES];
	logic [DW-1:0] tail_q [NUM_PIPES];
	logic [CW-1:0] fill_q [NUM_PIPES];
	logic [NUM_PIPES-1:0] active_q, valid_q;
	logic [TW-1:0] total_q;
	logic [PW-1:0] next_q, last_q;

	rrmpq_pkg::req_t req_q;
	logic [PW-1:0] pick_id, id_q;
	logic pick_ok;
	logic [LW-1:0] lim, n_q, left_q;
	logic sel_ok;
	logic [PW-1:0] sel;
	logic [CW-1:0] fill_sel, fill_pk;

	assign sel_ok = {{(32-SW){1'b0}}, req_q.pipe_sel} < NUM_PIPES;
	assign sel = sel_ok ? PW'(req_q.pipe_sel) : '0;
	assign fill_sel = fill_q[sel];

	always_comb begin
		logic [PW:0] idx;
		pick_ok = 1'b0;
		pick_id = '0;
		for (int i = NUM_PIPES; i >= 1; i--) begin
			idx = (PW+1)'(last_q) + (PW+1)'(i);
			if (idx >= (PW+1)'(NUM_PIPES)) idx = idx - (PW+1)'(NUM_PIPES);
			if (valid_q[idx[PW-1:0]] && fill_q[idx[PW-1:0]] != '0) begin
				pick_ok = 1'b1;
				pick_id = idx[PW-1:0];
			end
		end
		if (total_q == '0) pick_ok = 1'b0;
	end
	assign fill_pk = fill_q[pick_id];
	assign lim = (req_q.batch_limit > LW'(rrmpq_pkg::BATCH_MAX)) ?
		LW'(rrmpq_pkg::BATCH_MAX) : req_q.batch_limit;

	assign sts.is_pop = pick_ok && ((req_q.mode == rrmpq_pkg::MODE_DEQ) ||
		(req_q.mode == rrmpq_pkg::MODE_BATCH && lim != '0));
	assign sts.more = left_q > LW'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.exec && req_q.mode == rrmpq_pkg::MODE_ENQ && sel_ok &&
			fill_sel < CW'(PIPE_DEPTH))
			mem[sel][tail_q[sel]] <= req_q.data_in;
		if (cmd.pop) begin
			rsp_q.ok <= 1'b1;
			rsp_q.data_out <= mem[id_q][head_q[id_q]];
			rsp_q.pipe_out <= SW'(id_q);
			rsp_q.batch_total <= (req_q.mode == rrmpq_pkg::MODE_BATCH) ? n_q : '0;
			rsp_q.last <= left_q == LW'(1);
		end else if (cmd.emit) begin
			rsp_q <= '0;
			rsp_q.last <= 1'b1;
			case (req_q.mode)
				rrmpq_pkg::MODE_SUB: begin
					rsp_q.ok <= 1'b1;
					rsp_q.pipe_out <= SW'(next_q);
				end
				rrmpq_pkg::MODE_ENQ: if (sel_ok && fill_sel < CW'(PIPE_DEPTH)) begin
					rsp_q.ok <= 1'b1;
					rsp_q.pipe_out <= req_q.pipe_sel;
				end
				rrmpq_pkg::MODE_UNSUB: if (sel_ok) begin
					rsp_q.ok <= 1'b1;
					rsp_q.pipe_out <= req_q.pipe_sel;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PIPES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
			active_q <= '0;
			valid_q <= '0;
			total_q <= '0;
			next_q <= '0;
			last_q <= '0;
			id_q <= '0;
			n_q <= '0;
			left_q <= '0;
		end else if (cmd.exec) begin
			case (req_q.mode)
				rrmpq_pkg::MODE_SUB: begin
					active_q[next_q] <= 1'b1;
					next_q <= (next_q == PW'(NUM_PIPES - 1)) ? '0 : next_q + PW'(1);
				end
				rrmpq_pkg::MODE_ENQ: if (sel_ok && fill_sel < CW'(PIPE_DEPTH)) begin
					tail_q[sel] <= (tail_q[sel] == DW'(PIPE_DEPTH - 1)) ? '0 :
						tail_q[sel] + DW'(1);
					if (fill_sel == '0) valid_q[sel] <= 1'b1;
					fill_q[sel] <= fill_sel + CW'(1);
					total_q <= total_q + TW'(1);
				end
				rrmpq_pkg::MODE_UNSUB: if (sel_ok) begin
					active_q[sel] <= 1'b0;
					if (fill_sel == '0) valid_q[sel] <= 1'b0;
				end
				default: ;
			endcase
		end else if (cmd.pop) begin
			head_q[id_q] <= (head_q[id_q] == DW'(PIPE_DEPTH - 1)) ? '0 :
				head_q[id_q] + DW'(1);
			fill_q[id_q] <= fill_q[id_q] - CW'(1);
			total_q <= total_q - TW'(1);
			left_q <= left_q - LW'(1);
			if (left_q == LW'(1)) begin
				last_q <= id_q;
				if (fill_q[id_q] == CW'(1) && !active_q[id_q]) valid_q[id_q] <= 1'b0;
			end
		end else if (cmd.pick) begin
			id_q <= pick_id;
			if (req_q.mode == rrmpq_pkg::MODE_DEQ) begin
				n_q <= LW'(1);
				left_q <= LW'(1);
			end else begin
				n_q <= ({{(32-CW){1'b0}}, fill_pk} < {{(32-LW){1'b0}}, lim}) ?
					LW'(fill_pk) : lim;
				left_q <= ({{(32-CW){1'b0}}, fill_pk} < {{(32-LW){1'b0}}, lim}) ?
					LW'(fill_pk) : lim;
			end
		end
	end

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> fill_q[id_q] != '0) else $error("pop from empty pipe");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> left_q != '0) else $error("pop beyond batch");
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> total_q != '0) else $error("total underflow");
`endif
endmodule

// File: hw/rtl/round_robin_multi_pipe_queue_top.sv
// channel | dir | fields
// req     | in  | mode, pipe_sel, data_in, batch_limit
// rsp     | out | ok, data_out, pipe_out, batch_total, last
// A non-dequeue word is accepted, then executed (state read-modify-write).
// A dequeue picks its pipe in the execute cycle, then pops one item per cycle while
// the output is free, from the single-port item store.
// Output stalls hold execute and the pop sequencer. arst_n clears all pointers and masks.
module round_robin_multi_pipe_queue_top #(
	parameter int NUM_PIPES = rrmpq_pkg::NUM_PIPES,
	parameter int PIPE_DEPTH = rrmpq_pkg::PIPE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	rrmpq_req_if.sink req,
	rrmpq_rsp_if.source rsp
);
	rrmpq_pkg::cmd_t cmd;
	rrmpq_pkg::sts_t sts;

	rrmpq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts(sts), .cmd(cmd)
	);

	rrmpq_dp #(.NUM_PIPES(NUM_PIPES), .PIPE_DEPTH(PIPE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req.data),
		.cmd(cmd), .sts(sts), .rsp_q(rsp.data)
	);
endmodule

// File: verif/round_robin_multi_pipe_queue_top_test.sv
module round_robin_multi_pipe_queue_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	class queue_scoreboard;
		logic [rrmpq_pkg::DATA_W-1:0] store [rrmpq_pkg::NUM_PIPES][rrmpq_pkg::PIPE_DEPTH];
		int head [rrmpq_pkg::NUM_PIPES];
		int tail [rrmpq_pkg::NUM_PIPES];
		int fill [rrmpq_pkg::NUM_PIPES];
		logic [rrmpq_pkg::NUM_PIPES-1:0] active;
		logic [rrmpq_pkg::NUM_PIPES-1:0] vld_bits;
		int total;
		int next_id;
		int last_served;
		rrmpq_pkg::rsp_t pending [$];
		int errors;

		function new();
			for (int i = 0; i < rrmpq_pkg::NUM_PIPES; i++) begin
				head[i] = 0;
				tail[i] = 0;
				fill[i] = 0;
			end
			active = '0;
			vld_bits = '0;
			total = 0;
			next_id = 0;
			last_served = 0;
			errors = 0;
		endfunction

		function int pick_pipe();
			int id;
			if (total == 0)
				return -1;
			for (int i = 0; i < rrmpq_pkg::NUM_PIPES; i++) begin
				id = (last_served + 1 + i) % rrmpq_pkg::NUM_PIPES;
				if (vld_bits[id] && fill[id] > 0)
					return id;
			end
			return -1;
		endfunction

		function void push(logic ok, logic [rrmpq_pkg::DATA_W-1:0] d, int p, int n,
			logic lst);
			rrmpq_pkg::rsp_t r;
			r.ok = ok;
			r.data_out = d;
			r.pipe_out = p[rrmpq_pkg::SEL_W-1:0];
			r.batch_total = n[rrmpq_pkg::LIM_W-1:0];
			r.last = lst;
			pending.push_back(r);
		endfunction

		function logic [rrmpq_pkg::DATA_W-1:0] pop_item(int id);
			logic [rrmpq_pkg::DATA_W-1:0] v;
			v = store[id][head[id]];
			head[id] = (head[id] + 1) % rrmpq_pkg::PIPE_DEPTH;
			fill[id]--;
			total--;
			return v;
		endfunction

		function void drained(int id);
			if (fill[id] == 0 && !active[id])
				vld_bits[id] = 1'b0;
			last_served = id;
		endfunction

		function void note_request(rrmpq_pkg::req_t q);
			int id;
			int lim;
			int n;
			int sel;
			sel = q.pipe_sel;
			case (q.mode)
				rrmpq_pkg::MODE_SUB: begin
					id = next_id;
					active[id] = 1'b1;
					next_id = (id + 1) % rrmpq_pkg::NUM_PIPES;
					push(1, 0, id, 0, 1);
				end
				rrmpq_pkg::MODE_ENQ: begin
					if (sel >= rrmpq_pkg::NUM_PIPES || fill[sel] >= rrmpq_pkg::PIPE_DEPTH) begin
						push(0, 0, 0, 0, 1);
					end else begin
						store[sel][tail[sel]] = q.data_in;
						tail[sel] = (tail[sel] + 1) % rrmpq_pkg::PIPE_DEPTH;
						if (fill[sel] == 0)
							vld_bits[sel] = 1'b1;
						fill[sel]++;
						total++;
						push(1, 0, sel, 0, 1);
					end
				end
				rrmpq_pkg::MODE_DEQ: begin
					id = pick_pipe();
					if (id < 0) begin
						push(0, 0, 0, 0, 1);
					end else begin
						push(1, pop_item(id), id, 0, 1);
						drained(id);
					end
				end
				rrmpq_pkg::MODE_BATCH: begin
					lim = q.batch_limit > rrmpq_pkg::BATCH_MAX ? rrmpq_pkg::BATCH_MAX :
						q.batch_limit;
					id = (lim == 0) ? -1 : pick_pipe();
					if (id < 0) begin
						push(0, 0, 0, 0, 1);
					end else begin
						n = fill[id] < lim ? fill[id] : lim;
						for (int k = 0; k < n; k++)
							push(1, pop_item(id), id, n, k + 1 == n);
						drained(id);
					end
				end
				rrmpq_pkg::MODE_UNSUB: begin
					if (sel >= rrmpq_pkg::NUM_PIPES) begin
						push(0, 0, 0, 0, 1);
					end else begin
						active[sel] = 1'b0;
						if (fill[sel] == 0)
							vld_bits[sel] = 1'b0;
						push(1, 0, sel, 0, 1);
					end
				end
				default: push(0, 0, 0, 0, 1);
			endcase
		endfunction

		function void check_result(rrmpq_pkg::rsp_t r);
			rrmpq_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$error("unexpected word ok=%0b data=%h", r.ok, r.data_out);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (r.ok !== e.ok) begin
				$error("ok: expected %0b, actual %0b", e.ok, r.ok);
				errors++;
			end
			if (r.data_out !== e.data_out) begin
				$error("data_out: expected %h, actual %h", e.data_out, r.data_out);
				errors++;
			end
			if (r.pipe_out !== e.pipe_out) begin
				$error("pipe_out: expected %0d, actual %0d", e.pipe_out, r.pipe_out);
				errors++;
			end
			if (r.batch_total !== e.batch_total) begin
				$error("batch_total: expected %0d, actual %0d", e.batch_total,
					r.batch_total);
				errors++;
			end
			if (r.last !== e.last) begin
				$error("last: expected %0b, actual %0b", e.last, r.last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	rrmpq_req_if req ();
	rrmpq_rsp_if rsp ();
	queue_scoreboard sb;
	int idle_cycles;
	bit stall_on;

	round_robin_multi_pipe_queue_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_request(req.data);
			if (rsp.valid && rsp.ready)
				sb.check_result(rsp.data);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (idle_cycles > 5000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: alternates stretches of random stalls and stretches of none
	initial begin
		int run;
		rsp.ready = 1'b0;
		forever begin
			run = $urandom_range(1, 40);
			stall_on = $urandom_range(0, 2) != 0;
			repeat (run) begin
				@(negedge clk);
				rsp.ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
			end
		end
	end

	task automatic send_word(logic [2:0] mode, logic [2:0] sel, logic [31:0] d,
		logic [4:0] lim);
		rrmpq_pkg::req_t q;
		q.mode = mode;
		q.pipe_sel = sel;
		q.data_in = d;
		q.batch_limit = lim;
		req.data <= q;
		req.valid <= 1'b1;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic gap();
		req.valid <= 1'b0;
		repeat ($urandom_range(1, 6))
			@(negedge clk);
	endtask

	task automatic drain_wait();
		req.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (20)
			@(negedge clk);
	endtask

	task automatic random_word(int bias);
		int r;
		logic [2:0] mode;
		r = $urandom_range(0, 99);
		if (r < 6)
			mode = rrmpq_pkg::MODE_SUB;
		else if (r < 6 + bias)
			mode = rrmpq_pkg::MODE_ENQ;
		else if (r < 70)
			mode = rrmpq_pkg::MODE_DEQ;
		else if (r < 88)
			mode = rrmpq_pkg::MODE_BATCH;
		else if (r < 95)
			mode = rrmpq_pkg::MODE_UNSUB;
		else
			mode = 3'($urandom_range(5, 7));
		send_word(mode, 3'($urandom_range(0, 7)), $urandom,
			5'($urandom_range(0, 2) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 6)));
	endtask

	initial begin
		int burst;
		sb = new();
		arst_n = 1'b0;
		idle_cycles = 0;
		req.valid = 1'b0;
		req.data = '0;
		repeat (2)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed
		send_word(rrmpq_pkg::MODE_DEQ, 0, 0, 0);
		send_word(rrmpq_pkg::MODE_BATCH, 0, 0, 5'd16);
		send_word(rrmpq_pkg::MODE_SUB, 0, 0, 0);
		send_word(rrmpq_pkg::MODE_ENQ, 3'd7, 32'h7fffffff, 0);
		send_word(rrmpq_pkg::MODE_ENQ, 3'd7, 32'h80000000, 0);
		send_word(rrmpq_pkg::MODE_ENQ, 3'd1, 32'hffffffff, 0);
		send_word(rrmpq_pkg::MODE_ENQ, 3'd0, 32'h0, 0);
		send_word(rrmpq_pkg::MODE_BATCH, 0, 0, 5'd0);
		send_word(rrmpq_pkg::MODE_DEQ, 0, 0, 0);
		send_word(rrmpq_pkg::MODE_UNSUB, 3'd7, 0, 0);
		send_word(rrmpq_pkg::MODE_BATCH, 0, 0, 5'd31);
		for (int i = 0; i < 17; i++)
			send_word(rrmpq_pkg::MODE_ENQ, 3'd2, i * 32'h1357_9bdf, 0);
		send_word(rrmpq_pkg::MODE_BATCH, 0, 0, 5'd17);
		send_word(rrmpq_pkg::MODE_UNSUB, 3'd0, 0, 0);
		send_word(3'd5, 3'd5, 32'h5a5a5a5a, 5'd3);
		send_word(3'd7, 3'd2, 0, 0);
		drain_wait();

		// random, with phases of fill-heavy and drain-heavy traffic
		for (int i = 0; i < 440;) begin
			burst = $urandom_range(1, 20);
			for (int j = 0; j < burst; j++, i++)
				random_word((i / 60) % 2 ? 50 : 20);
			if ($urandom_range(0, 9) == 0)
				drain_wait();
			else if ($urandom_range(0, 2) != 0)
				gap();
		end
		drain_wait();
		repeat (30)
			@(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
